// ===== src/sld_pkg.sv =====
package sld_pkg;

  localparam int ADDR_W     = 20;
  localparam int PIXELS     = 1 << ADDR_W;
  localparam int CODE_BITS  = 16;
  localparam int BITPOS_W   = 4;
  localparam int LEVEL_W    = 8;
  localparam int OUT_CODE_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_GRAY_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROBUST_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIRECT  = 2'd2;

  typedef logic [LEVEL_W-1:0]   level_t;
  typedef logic [CODE_BITS-1:0] code_t;

  typedef enum logic [1:0] {
    CLS_ZERO,
    CLS_ONE,
    CLS_UNC
  } sld_cls_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   pixel_index;
    logic                first_pair;
    logic                channel;
    logic [BITPOS_W-1:0] bit_position;
    level_t              value_pos;
    level_t              value_neg;
    level_t              direct_est;
    level_t              global_light;
  } sld_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0]     out_pixel;
    logic [OUT_CODE_W-1:0] column_code;
    logic                  column_uncertain;
    logic [OUT_CODE_W-1:0] row_code;
    logic                  row_uncertain;
    level_t                min_level;
    level_t                max_level;
  } sld_out_t;

  // One store entry per pixel: both codes, sticky flags and the level range.
  typedef struct packed {
    code_t  row_code;
    code_t  col_code;
    logic   row_unc;
    logic   col_unc;
    level_t max_level;
    level_t min_level;
  } sld_entry_t;

  localparam int ENTRY_W = $bits(sld_entry_t);

  function automatic code_t gray_to_bin(input code_t g);
    code_t b;
    b = g;
    for (int s = 1; s < CODE_BITS; s = s << 1) begin
      b = b ^ (b >> s);
    end
    return b;
  endfunction

endpackage

// ===== src/sld_in_if.sv =====
interface sld_in_if import sld_pkg::*; ();
  logic    valid;
  logic    ready;
  sld_in_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== src/sld_out_if.sv =====
interface sld_out_if import sld_pkg::*; ();
  logic     valid;
  logic     ready;
  sld_out_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== src/sld_ram.sv =====
module sld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/structured_light_pixel_decoder_top.sv =====
// A beat is registered in stage 1, stage 2 and stage 3 and then in the output register.
// Throughput: one beat per cycle while the output is not stalled; the per-pixel store has one read and one write port,
// and the read-modify-write hazard is covered by forwarding the last two writes.
// An output stall freezes every stage at once, so nothing is dropped or repeated.
// Reset clears the stage valid bits and the registers (gray mode on, others off); the
// store is not cleared, and an entry holds no meaning until a first pair writes it.
module structured_light_pixel_decoder_top import sld_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  sld_in_if.sink                pix_in,
  sld_out_if.source             pix_out
);

  logic   gray_mode;
  logic   robust_mode;
  level_t min_direct;

  always_ff @(posedge clk) begin
    if (rst) begin
      gray_mode   <= 1'b1;
      robust_mode <= 1'b0;
      min_direct  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRAY_MODE:   gray_mode   <= cfg_data[0];
        CFG_ROBUST_MODE: robust_mode <= cfg_data[0];
        CFG_MIN_DIRECT:  min_direct  <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  logic     out_valid;
  sld_out_t out_data;
  logic     adv;

  assign adv          = !out_valid || pix_out.ready;
  assign pix_in.ready = adv;

  // Stage 1: the store read is in flight, classification runs on the beat.
  logic       v1;
  sld_in_t    p1;
  sld_entry_t ram_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= pix_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1 <= pix_in.data;
    end
  end

  sld_cls_t cls1;
  level_t   pmin1;
  level_t   pmax1;

  always_comb begin
    if (p1.direct_est < min_direct) begin
      cls1 = CLS_UNC;
    end else if (p1.direct_est > p1.global_light) begin
      cls1 = (p1.value_pos > p1.value_neg) ? CLS_ONE : CLS_ZERO;
    end else if (p1.value_pos <= p1.direct_est && p1.value_neg >= p1.global_light) begin
      cls1 = CLS_ZERO;
    end else if (p1.value_pos >= p1.global_light && p1.value_neg <= p1.direct_est) begin
      cls1 = CLS_ONE;
    end else begin
      cls1 = CLS_UNC;
    end
    pmin1 = (p1.value_pos < p1.value_neg) ? p1.value_pos : p1.value_neg;
    pmax1 = (p1.value_pos > p1.value_neg) ? p1.value_pos : p1.value_neg;
  end

  // Stage 2: forward, merge and write back.
  logic       v2;
  sld_in_t    p2;
  sld_cls_t   cls2;
  level_t     pmin2;
  level_t     pmax2;
  sld_entry_t old2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2    <= p1;
      cls2  <= cls1;
      pmin2 <= pmin1;
      pmax2 <= pmax1;
      old2  <= ram_q;
    end
  end

  // Writes made since this beat's read by the two beats ahead of it are not in old2.
  logic              h1_v;
  logic [ADDR_W-1:0] h1_addr;
  sld_entry_t        h1_data;
  logic              h2_v;
  logic [ADDR_W-1:0] h2_addr;
  sld_entry_t        h2_data;

  sld_entry_t cur2;
  sld_entry_t new2;
  logic       unc_bit;
  logic       set_bit;
  code_t      bit_mask;

  always_comb begin
    if (h1_v && h1_addr == p2.pixel_index) begin
      cur2 = h1_data;
    end else if (h2_v && h2_addr == p2.pixel_index) begin
      cur2 = h2_data;
    end else begin
      cur2 = old2;
    end

    new2 = cur2;
    if (p2.first_pair) begin
      new2.row_code  = '0;
      new2.col_code  = '0;
      new2.row_unc   = 1'b0;
      new2.col_unc   = 1'b0;
      new2.min_level = pmin2;
      new2.max_level = pmax2;
    end else begin
      if (pmin2 < cur2.min_level) begin
        new2.min_level = pmin2;
      end
      if (pmax2 > cur2.max_level) begin
        new2.max_level = pmax2;
      end
    end

    unc_bit = p2.channel ? new2.row_unc : new2.col_unc;
    set_bit = 1'b0;
    if (!robust_mode) begin
      set_bit = p2.value_pos > p2.value_neg;
    end else if (!unc_bit) begin
      if (cls2 == CLS_UNC) begin
        if (p2.channel) begin
          new2.row_unc = 1'b1;
        end else begin
          new2.col_unc = 1'b1;
        end
      end else begin
        set_bit = cls2 == CLS_ONE;
      end
    end

    // The 4-bit position always falls inside the 16-bit code, so the mask has one bit set.
    bit_mask = {{(CODE_BITS-1){1'b0}}, 1'b1} << p2.bit_position;
    if (set_bit) begin
      if (p2.channel) begin
        new2.row_code = new2.row_code | bit_mask;
      end else begin
        new2.col_code = new2.col_code | bit_mask;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h1_v <= 1'b0;
      h2_v <= 1'b0;
    end else if (adv) begin
      h1_v <= v2;
      h2_v <= h1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h1_addr <= p2.pixel_index;
      h1_data <= new2;
      h2_addr <= h1_addr;
      h2_data <= h1_data;
    end
  end

  sld_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(PIXELS)
  ) u_store (
    .clk  (clk),
    .we   (adv && v2),
    .waddr(p2.pixel_index),
    .wdata(new2),
    .re   (adv),
    .raddr(pix_in.data.pixel_index),
    .rdata(ram_q)
  );

  // Stage 3: updated entry waits for code decoding.
  logic              v3;
  logic [ADDR_W-1:0] pix3;
  sld_entry_t        e3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix3 <= p2.pixel_index;
      e3   <= new2;
    end
  end

  code_t col_shown;
  code_t row_shown;

  always_comb begin
    col_shown = gray_mode ? gray_to_bin(e3.col_code) : e3.col_code;
    row_shown = gray_mode ? gray_to_bin(e3.row_code) : e3.row_code;
    if (e3.col_unc) begin
      col_shown = '0;
    end
    if (e3.row_unc) begin
      row_shown = '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.out_pixel        <= pix3;
      out_data.column_code      <= OUT_CODE_W'(col_shown);
      out_data.column_uncertain <= e3.col_unc;
      out_data.row_code         <= OUT_CODE_W'(row_shown);
      out_data.row_uncertain    <= e3.row_unc;
      out_data.min_level        <= e3.min_level;
      out_data.max_level        <= e3.max_level;
    end
  end

  assign pix_out.valid = out_valid;
  assign pix_out.data  = out_data;

endmodule

// ===== src/sld_checker.sv =====
module sld_checker import sld_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input sld_out_t out_data
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat valid after reset");

  // A beat that is not taken stays, unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  // An uncertain channel never shows a code.
  a_unc_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.column_uncertain || out_data.column_code == '0) &&
                  (!out_data.row_uncertain || out_data.row_code == '0))
    else $error("uncertain channel shows a nonzero code");

  // With nothing waiting at the output, the input side must take a beat.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while output is empty");

endmodule

bind structured_light_pixel_decoder_top sld_checker u_sld_checker (
  .clk      (clk),
  .rst      (rst),
  .in_ready (pix_in.ready),
  .out_valid(pix_out.valid),
  .out_ready(pix_out.ready),
  .out_data (pix_out.data)
);
